// File: rtl/core/bpa_pkg.sv
// bpa_pkg: types, codes and fixed widths for the bitmap page allocator
// used by the channel interface, the allocator core and its helpers
package bpa_pkg;

  // wide page index / count width, holds any page number plus headroom
  localparam int IW = 34;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_ALIGNED = 3'd1,
    OP_FIXED   = 3'd2,
    OP_FREE    = 3'd3,
    OP_RESERVE = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_NOFIT  = 2'd1,
    STAT_RANGE  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE   = 8'd0,
    REG_PAGES  = 8'd1,
    REG_MMU    = 8'd2,
    REG_VOFF   = 8'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_DIV, S_ALIGN0, S_CAND, S_SCAN,
    S_LOAD, S_LOADW, S_ADV, S_MARK_RD, S_MARK_WR, S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] address;
    logic [31:0] byte_count;
    logic [32:0] alignment;
  } req_t;

  typedef struct packed {
    logic [63:0] result_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          value;
  } cfg_t;

endpackage

// File: rtl/core/bpa_chan_if.sv
// bpa_chan_if: valid/ready channel carrying one payload beat
// payload type comes in as a parameter, normally a bpa_pkg struct
interface bpa_chan_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bpa_ram.sv
// bpa_ram: generic one-write one-read synchronous memory
// read data is registered; no dependencies
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/bpa_divrem.sv
// bpa_divrem: restoring remainder unit, one dividend bit per cycle
// gives base modulo alignment for the aligned search; uses bpa_pkg-free widths
module bpa_divrem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [32:0] rem
);
  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] shreg;
  logic [33:0] acc;
  logic [33:0] trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {acc[32:0], shreg[63]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      acc   <= '0;
    end else if (busy) begin
      shreg <= {shreg[62:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        acc <= trial - {1'b0, divisor};
      end else begin
        acc <= trial;
      end
    end
  end

  assign rem = acc[32:0];
endmodule

// File: rtl/core/bitmap_page_allocator.sv
// bitmap_page_allocator: first-fit page allocator over a used-page bitmap
// depends on bpa_pkg, bpa_chan_if, bpa_ram, bpa_divrem
//
//  channel  dir  payload                                   beat taken when
//  req      in   opcode, address, byte_count, alignment    req.valid & req.ready
//  rsp      out  result_address, status                    rsp.valid & rsp.ready
//  cfg      in   index, value                              cfg.valid & cfg.ready
//
// one request at a time; alloc, aligned and fixed requests test one page per
// cycle while its bitmap word is held, fetching each new word via S_LOAD and
// S_LOADW, so time grows with the pages walked; aligned requests above one
// page first wait in S_DIV on base modulo alignment, then place the first
// candidate in S_ALIGN0. marking or clearing a run reads, then writes, each
// bitmap word. after reset a clearing pass writes NWORDS words, one a cycle,
// with req.ready low; cfg is always ready. a waiting result does not block
// the next request beat from being taken in the same cycle it leaves.
module bitmap_page_allocator #(
  parameter int MAX_PAGES  = 16384,
  parameter int PG_LOG2    = 12,
  parameter int WORD_BITS  = 64
) (
  input logic        clk,
  input logic        rst,
  bpa_chan_if.sink   req,
  bpa_chan_if.source rsp,
  bpa_chan_if.sink   cfg
);
  import bpa_pkg::*;

  localparam int WB     = $clog2(WORD_BITS);
  localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = $clog2(NWORDS > 1 ? NWORDS : 2);
  localparam logic [63:0] PG = 64'd1 << PG_LOG2;

  // configuration registers
  logic [63:0] region_base;
  logic [14:0] region_pages;
  logic        mmu_enabled;
  logic [63:0] virt_offset;

  // control and datapath registers
  state_t              state, state_next;
  logic [2:0]          op, op_next;
  logic                amode, amode_next;
  logic [63:0]         addr_r, addr_r_next;
  logic [31:0]         bytes_r, bytes_r_next;
  logic [32:0]         align_r, align_r_next;
  logic [IW-1:0]       n, n_next;
  logic [32:0]         alr, alr_next;
  logic [IW-1:0]       ap, ap_next;
  logic [IW-1:0]       c, c_next;
  logic [IW-1:0]       p, p_next;
  logic [63:0]         a, a_next;
  logic [IW-1:0]       s, s_next;
  logic [IW-1:0]       e, e_next;
  logic [IW-1:0]       w, w_next;
  logic                setv, setv_next;
  logic [WORD_BITS-1:0] wreg, wreg_next;
  logic [AW-1:0]       wi, wi_next;
  logic                loaded, loaded_next;
  status_t             st, st_next;
  logic                rsp_valid, rsp_valid_next;
  rsp_t                rsp_data, rsp_data_next;

  // memory and divider hookups
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
  logic                 div_start, div_done;
  logic [32:0]          div_rem;

  // shared combinational values
  logic [IW-1:0]        lim;
  logic [63:0]          off;
  logic                 in_region;
  logic [63:0]          size_b;
  logic [IW-1:0]        off_pg;
  logic [IW-1:0]        run_end;
  logic [32:0]         alr_m_rem;
  logic [64:0]         sum65;
  logic [WORD_BITS-1:0] wmask;
  logic [IW-1:0]        wbase;
  logic                 req_fire;
  logic [32:0]          n_wide;

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bpa_divrem u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (region_base),
    .divisor  (alr),
    .done     (div_done),
    .rem      (div_rem)
  );

  // configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= 64'd2147483648;
      region_pages <= 15'd16384;
      mmu_enabled  <= 1'b0;
      virt_offset  <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_BASE:  region_base  <= cfg.data.value;
        REG_PAGES: region_pages <= cfg.data.value[14:0];
        REG_MMU:   mmu_enabled  <= cfg.data.value[0];
        REG_VOFF:  virt_offset  <= cfg.data.value;
        default:   ;
      endcase
    end
  end

  // region geometry
  always_comb begin
    lim       = (IW'(region_pages) > IW'(MAX_PAGES)) ? IW'(MAX_PAGES) : IW'(region_pages);
    off       = addr_r - region_base;
    in_region = (addr_r >= region_base) && ((off >> PG_LOG2) < 64'(lim));
    off_pg    = IW'(off >> PG_LOG2);
    size_b    = 64'(lim) << PG_LOG2;
    run_end   = ((off_pg + n) > lim) ? lim : (off_pg + n);
    alr_m_rem = alr - div_rem;
    sum65     = {1'b0, region_base} + 65'(alr_m_rem);
    wbase     = w << WB;
    n_wide    = ({1'b0, req.data.byte_count} + 33'(PG - 64'd1)) >> PG_LOG2;
  end

  // per-page mask of the run within the current word
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      wmask[i] = ((wbase + IW'(i)) >= s) && ((wbase + IW'(i)) < e);
    end
  end

  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
      w         <= '0;
      loaded    <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      w         <= w_next;
      loaded    <= loaded_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op       <= op_next;
    amode    <= amode_next;
    addr_r   <= addr_r_next;
    bytes_r  <= bytes_r_next;
    align_r  <= align_r_next;
    n        <= n_next;
    alr      <= alr_next;
    ap       <= ap_next;
    c        <= c_next;
    p        <= p_next;
    a        <= a_next;
    s        <= s_next;
    e        <= e_next;
    setv     <= setv_next;
    wreg     <= wreg_next;
    wi       <= wi_next;
    st       <= st_next;
    rsp_data <= rsp_data_next;
  end

  // sequencer: next state, datapath updates and memory control
  always_comb begin
    state_next     = state;
    op_next        = op;
    amode_next     = amode;
    addr_r_next    = addr_r;
    bytes_r_next   = bytes_r;
    align_r_next   = align_r;
    n_next         = n;
    alr_next       = alr;
    ap_next        = ap;
    c_next         = c;
    p_next         = p;
    a_next         = a;
    s_next         = s;
    e_next         = e;
    w_next         = w;
    setv_next      = setv;
    wreg_next      = wreg;
    wi_next        = wi;
    loaded_next    = loaded;
    st_next        = st;
    rsp_valid_next = rsp_valid;
    rsp_data_next  = rsp_data;
    mem_we         = 1'b0;
    mem_waddr      = w[AW-1:0];
    mem_wdata      = '0;
    mem_raddr      = w[AW-1:0];
    div_start      = 1'b0;

    if (rsp_valid && rsp.ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      // zero the bitmap after reset
      S_CLEAR: begin
        mem_we = 1'b1;
        w_next = w + IW'(1);
        if (w == IW'(NWORDS - 1)) begin
          w_next     = '0;
          state_next = S_IDLE;
        end
      end

      // take a request beat, free addresses lose the offset here when the MMU is on
      S_IDLE: begin
        if (req_fire) begin
          op_next      = req.data.opcode;
          addr_r_next  = (req.data.opcode == OP_FREE && mmu_enabled)
                         ? req.data.address - virt_offset : req.data.address;
          bytes_r_next = req.data.byte_count;
          align_r_next = req.data.alignment;
          n_next       = IW'(n_wide);
          loaded_next  = 1'b0;
          amode_next   = 1'b0;
          state_next   = S_PREP;
        end
      end

      // decode the request and set up the walk or the mark
      S_PREP: begin
        st_next    = STAT_NOFIT;
        state_next = S_FINISH;
        if (n != '0) begin
          case (op)
            OP_ALLOC: begin
              c_next     = '0;
              state_next = S_CAND;
            end
            OP_ALIGNED: begin
              if ({31'b0, align_r} <= PG) begin
                c_next     = '0;
                state_next = S_CAND;
              end else begin
                amode_next = 1'b1;
                alr_next   = align_r & ~33'(PG - 64'd1);
                ap_next    = IW'(align_r >> PG_LOG2);
                state_next = S_DIV;
              end
            end
            OP_FIXED: begin
              if (!in_region) begin
                st_next = STAT_RANGE;
              end else begin
                c_next     = off_pg;
                a_next     = addr_r;
                state_next = S_CAND;
              end
            end
            OP_FREE: begin
              if (!in_region) begin
                st_next = STAT_RANGE;
              end else begin
                s_next     = off_pg;
                e_next     = run_end;
                w_next     = off_pg >> WB;
                setv_next  = 1'b0;
                state_next = S_MARK_RD;
              end
            end
            OP_RESERVE: begin
              if (addr_r < region_base || off > size_b
                  || {32'b0, bytes_r} > size_b - off) begin
                st_next = STAT_RANGE;
              end else begin
                s_next     = off_pg;
                e_next     = run_end;
                w_next     = off_pg >> WB;
                setv_next  = 1'b1;
                state_next = S_MARK_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // wait for base modulo alignment, launched from S_PREP
      S_DIV: begin
        if (!div_start && div_done) begin
          state_next = S_ALIGN0;
        end
      end

      // first aligned candidate at or above the base
      S_ALIGN0: begin
        if (div_rem == '0) begin
          a_next     = region_base;
          c_next     = '0;
          state_next = S_CAND;
        end else if (sum65[64]) begin
          st_next    = STAT_NOFIT;
          state_next = S_FINISH;
        end else begin
          a_next     = sum65[63:0];
          c_next     = IW'(alr_m_rem >> PG_LOG2);
          state_next = S_CAND;
        end
      end

      // bounds of a candidate run
      S_CAND: begin
        if (c >= lim || n > lim - c) begin
          st_next    = STAT_NOFIT;
          state_next = S_FINISH;
        end else begin
          p_next     = c;
          state_next = S_SCAN;
        end
      end

      // test one page of the candidate run
      S_SCAN: begin
        if (p == c + n) begin
          if (op == OP_ALLOC || (op == OP_ALIGNED && !amode)) begin
            a_next = region_base + (64'(c) << PG_LOG2);
          end
          s_next     = c;
          e_next     = c + n;
          w_next     = c >> WB;
          setv_next  = 1'b1;
          state_next = S_MARK_RD;
        end else if (loaded && wi == p[AW+WB-1:WB]) begin
          if (wreg[p[WB-1:0]]) begin
            if (op == OP_FIXED) begin
              st_next    = STAT_NOFIT;
              state_next = S_FINISH;
            end else if (amode) begin
              state_next = S_ADV;
            end else begin
              c_next     = p + IW'(1);
              state_next = S_CAND;
            end
          end else begin
            p_next = p + IW'(1);
          end
        end else begin
          state_next = S_LOAD;
        end
      end

      // fetch the word that holds the page under test
      S_LOAD: begin
        mem_raddr  = p[AW+WB-1:WB];
        state_next = S_LOADW;
      end

      S_LOADW: begin
        wreg_next   = mem_rdata;
        wi_next     = p[AW+WB-1:WB];
        loaded_next = 1'b1;
        state_next  = S_SCAN;
      end

      // step aligned candidates past the used page
      S_ADV: begin
        if (c > p) begin
          state_next = S_CAND;
        end else if (({1'b0, a} + 65'(alr)) > 65'h0_FFFF_FFFF_FFFF_FFFF) begin
          st_next    = STAT_NOFIT;
          state_next = S_FINISH;
        end else begin
          a_next = a + 64'(alr);
          c_next = c + ap;
        end
      end

      // read-modify-write of each word the run touches
      S_MARK_RD: begin
        if (wbase >= e) begin
          st_next    = STAT_DONE;
          state_next = S_FINISH;
        end else begin
          mem_raddr  = w[AW-1:0];
          state_next = S_MARK_WR;
        end
      end

      S_MARK_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = setv ? (mem_rdata | wmask) : (mem_rdata & ~wmask);
        w_next     = w + IW'(1);
        state_next = S_MARK_RD;
      end

      // post the result beat
      S_FINISH: begin
        rsp_valid_next         = 1'b1;
        rsp_data_next.status   = st;
        rsp_data_next.result_address = '0;
        if (st == STAT_DONE && (op == OP_ALLOC || op == OP_ALIGNED || op == OP_FIXED)) begin
          rsp_data_next.result_address = mmu_enabled ? a + virt_offset : a;
        end
        w_next     = '0;
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase

    if (state == S_PREP && op == OP_ALIGNED && n != '0
        && {31'b0, align_r} > PG) begin
      div_start = 1'b1;
    end
  end

  // failed results carry a zero address (non-allocating results also get one in S_FINISH)
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status != STAT_DONE |-> rsp.data.result_address == '0)
    else $error("failed result with nonzero address");

  // the bitmap is never written while a run is being tested
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_LOAD || state == S_LOADW) |-> !mem_we)
    else $error("bitmap write during scan");

  // no request taken before the clearing pass ends or while busy
  assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE && !(rsp_valid && !rsp.ready))
    else $error("request taken while busy");
endmodule
